>>> sv/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, constants and helper functions of the bracket balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int TYPE_W      = 2;

   localparam logic [7:0] CH_PAREN_OPEN   = 8'h28;  // (
   localparam logic [7:0] CH_PAREN_CLOSE  = 8'h29;  // )
   localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5B;  // [
   localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D;  // ]
   localparam logic [7:0] CH_CURLY_OPEN   = 8'h7B;  // {
   localparam logic [7:0] CH_CURLY_CLOSE  = 8'h7D;  // }

   localparam logic [TYPE_W-1:0] BT_PAREN  = 2'd0;
   localparam logic [TYPE_W-1:0] BT_SQUARE = 2'd1;
   localparam logic [TYPE_W-1:0] BT_CURLY  = 2'd2;
   localparam logic [TYPE_W-1:0] BT_NONE   = 2'd3;

   typedef enum logic [1:0] {
      ST_BALANCED   = 2'd0,
      ST_BAD_CLOSER = 2'd1,
      ST_MISSING    = 2'd2,
      ST_OVERFLOW   = 2'd3
   } bbc_status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_CHECK,
      FSM_DRAIN
   } bbc_state_type;

   function automatic logic [TYPE_W-1:0] opener_type(input logic [7:0] ch);
      case (ch)
         CH_PAREN_OPEN:  opener_type = BT_PAREN;
         CH_SQUARE_OPEN: opener_type = BT_SQUARE;
         CH_CURLY_OPEN:  opener_type = BT_CURLY;
         default:        opener_type = BT_NONE;
      endcase
   endfunction

   function automatic logic [TYPE_W-1:0] closer_type(input logic [7:0] ch);
      case (ch)
         CH_PAREN_CLOSE:  closer_type = BT_PAREN;
         CH_SQUARE_CLOSE: closer_type = BT_SQUARE;
         CH_CURLY_CLOSE:  closer_type = BT_CURLY;
         default:         closer_type = BT_NONE;
      endcase
   endfunction

   function automatic logic [7:0] closer_char(input logic [TYPE_W-1:0] t);
      case (t)
         BT_PAREN:  closer_char = CH_PAREN_CLOSE;
         BT_SQUARE: closer_char = CH_SQUARE_CLOSE;
         BT_CURLY:  closer_char = CH_CURLY_CLOSE;
         default:   closer_char = 8'h00;
      endcase
   endfunction

endpackage

>>> sv/bbc_req_if.sv
// ----------------------------------------------------------------------------
// bbc_req_if
// Character channel: one text byte or an end-of-string beat.
// ----------------------------------------------------------------------------
interface bbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       end_marker;

   modport source (output valid, output symbol, output end_marker, input ready);
   modport sink   (input valid, input symbol, input end_marker, output ready);
endinterface

>>> sv/bbc_rsp_if.sv
// ----------------------------------------------------------------------------
// bbc_rsp_if
// Result channel: one verdict or error report per beat.
// ----------------------------------------------------------------------------
interface bbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] position;
   logic [7:0]  char_out;
   logic        last_of_run;

   modport source (output valid, output status, output position, output char_out,
                   output last_of_run, input ready);
   modport sink   (input valid, input status, input position, input char_out,
                   input last_of_run, output ready);
endinterface

>>> sv/bbc_ram.sv
// ----------------------------------------------------------------------------
// bbc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bbc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/bracket_balance_checker.sv
// Timing: an overflow or empty-stack report is valid the cycle after its beat
//   is taken, a mismatched closer after the stack RAM read and the check state;
//   missing closers follow the end beat's RAM read, one per cycle while rsp is ready.
// Flow: one beat per cycle for openers and plain bytes; a closer holds input
//   until its check ends, an end beat with open brackets until the drain ends; stalls on rsp.
// Reset: synchronous, active high; clears counters, error flag, output valid.
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Balanced-bracket check over a character stream with a RAM-based stack.
// ----------------------------------------------------------------------------
module bracket_balance_checker (
   input  logic   clock,
   input  logic   reset,
   bbc_req_if.sink   req_chan,
   bbc_rsp_if.source rsp_chan
);

   // control state
   bbc_pkg::bbc_state_type          state_ff, state_in;
   logic [bbc_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [15:0]                     idx_ff, idx_in;
   logic                            err_ff, err_in;

   // per-item scratch: closer under check, position for drain reports
   logic [7:0]                      sym_ff, sym_in;
   logic [15:0]                     pos_ff, pos_in;
   logic [bbc_pkg::TYPE_W-1:0]      type_ff, type_in;

   // output register
   logic                            out_valid_ff, out_valid_in;
   logic [1:0]                      out_status_ff, out_status_in;
   logic [15:0]                     out_pos_ff, out_pos_in;
   logic [7:0]                      out_char_ff, out_char_in;
   logic                            out_last_ff, out_last_in;

   // stack RAM ports
   logic                            ram_we;
   logic [bbc_pkg::ADDR_W-1:0]      ram_waddr;
   logic [bbc_pkg::TYPE_W-1:0]      ram_wdata;
   logic                            ram_re;
   logic [bbc_pkg::ADDR_W-1:0]      ram_raddr;
   logic [bbc_pkg::TYPE_W-1:0]      ram_rdata;

   logic                            out_free;
   logic                            req_take;
   logic [bbc_pkg::CNT_W-1:0]       count_dec;
   logic [bbc_pkg::TYPE_W-1:0]      open_t;
   logic [bbc_pkg::TYPE_W-1:0]      close_t;

   bbc_ram #(
      .WIDTH (bbc_pkg::TYPE_W),
      .DEPTH (bbc_pkg::STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // the output register is free when empty or when its beat leaves now
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   // take a character only while idle and with room for a possible report
   assign req_chan.ready = (state_ff == bbc_pkg::FSM_IDLE) && out_free;
   assign req_take  = req_chan.valid && req_chan.ready;

   assign count_dec = count_ff - bbc_pkg::CNT_W'(1);
   assign open_t    = bbc_pkg::opener_type(req_chan.symbol);
   assign close_t   = bbc_pkg::closer_type(req_chan.symbol);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      err_in        = err_ff;
      sym_in        = sym_ff;
      pos_in        = pos_ff;
      type_in       = type_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_status_in = out_status_ff;
      out_pos_in    = out_pos_ff;
      out_char_in   = out_char_ff;
      out_last_in   = out_last_ff;
      ram_we        = 1'b0;
      ram_waddr     = count_ff[bbc_pkg::ADDR_W-1:0];
      ram_wdata     = open_t;
      ram_re        = 1'b0;
      // every pop reads the entry just below the current count
      ram_raddr     = count_dec[bbc_pkg::ADDR_W-1:0];

      case (state_ff)
         bbc_pkg::FSM_IDLE: begin
            if (req_take) begin
               if (req_chan.end_marker) begin
                  if (err_ff) begin
                     // error already reported: drop the verdict, reset
                     count_in = '0;
                     idx_in   = '0;
                     err_in   = 1'b0;
                  end else if (count_ff == '0) begin
                     out_valid_in  = 1'b1;
                     out_status_in = bbc_pkg::ST_BALANCED;
                     out_pos_in    = '0;
                     out_char_in   = '0;
                     out_last_in   = 1'b1;
                     idx_in        = '0;
                  end else begin
                     // start the drain: pop the innermost opener
                     ram_re   = 1'b1;
                     count_in = count_dec;
                     pos_in   = idx_ff;
                     state_in = bbc_pkg::FSM_DRAIN;
                  end
               end else begin
                  // advance the saturating character index
                  if (idx_ff != 16'hFFFF) begin
                     idx_in = idx_ff + 16'd1;
                  end
                  if (!err_ff) begin
                     if (open_t != bbc_pkg::BT_NONE) begin
                        if (count_ff != bbc_pkg::CNT_W'(bbc_pkg::STACK_DEPTH)) begin
                           ram_we   = 1'b1;
                           count_in = count_ff + bbc_pkg::CNT_W'(1);
                        end else begin
                           out_valid_in  = 1'b1;
                           out_status_in = bbc_pkg::ST_OVERFLOW;
                           out_pos_in    = idx_ff;
                           out_char_in   = req_chan.symbol;
                           out_last_in   = 1'b1;
                           err_in        = 1'b1;
                        end
                     end else if (close_t != bbc_pkg::BT_NONE) begin
                        if (count_ff == '0) begin
                           // closer with nothing open
                           out_valid_in  = 1'b1;
                           out_status_in = bbc_pkg::ST_BAD_CLOSER;
                           out_pos_in    = idx_ff;
                           out_char_in   = req_chan.symbol;
                           out_last_in   = 1'b1;
                           err_in        = 1'b1;
                        end else begin
                           // pop now, compare when the RAM word arrives
                           ram_re   = 1'b1;
                           count_in = count_dec;
                           sym_in   = req_chan.symbol;
                           pos_in   = idx_ff;
                           type_in  = close_t;
                           state_in = bbc_pkg::FSM_CHECK;
                        end
                     end
                  end
               end
            end
         end

         bbc_pkg::FSM_CHECK: begin
            // the output register is empty here: it was free at the take
            if (ram_rdata != type_ff) begin
               out_valid_in  = 1'b1;
               out_status_in = bbc_pkg::ST_BAD_CLOSER;
               out_pos_in    = pos_ff;
               out_char_in   = sym_ff;
               out_last_in   = 1'b1;
               err_in        = 1'b1;
            end
            state_in = bbc_pkg::FSM_IDLE;
         end

         bbc_pkg::FSM_DRAIN: begin
            // hold the popped word until the output register has room
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = bbc_pkg::ST_MISSING;
               out_pos_in    = pos_ff;
               out_char_in   = bbc_pkg::closer_char(ram_rdata);
               out_last_in   = (count_ff == '0);
               if (count_ff == '0) begin
                  idx_in   = '0;
                  state_in = bbc_pkg::FSM_IDLE;
               end else begin
                  ram_re   = 1'b1;
                  count_in = count_dec;
               end
            end
         end

         default: begin
            state_in = bbc_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bbc_pkg::FSM_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         err_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      pos_ff        <= pos_in;
      type_ff       <= type_in;
      out_status_ff <= out_status_in;
      out_pos_ff    <= out_pos_in;
      out_char_ff   <= out_char_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = out_status_ff;
   assign rsp_chan.position    = out_pos_ff;
   assign rsp_chan.char_out    = out_char_ff;
   assign rsp_chan.last_of_run = out_last_ff;

endmodule
